### src/rpdd_pkg.sv
// Shared types, codes and constants of the rumble pulse-density driver.
package rpdd_pkg;

  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_UPLOAD = 2'd1;
  localparam logic [1:0] ACT_ERASE  = 2'd2;
  localparam logic [1:0] ACT_PLAY   = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [15:0] FULL_LEVEL = 16'hFFFF;

  localparam logic [6:0] STRENGTH_MAX   = 7'd100;
  localparam logic [6:0] STRENGTH_RESET = 7'd100;

  // Scaled product: magnitude * percent + rounding bias, below 2^23.
  localparam int          PROD_W     = 23;
  localparam logic [6:0]  ROUND_BIAS = 7'd50;
  // Divide by 100 as multiply by ceil(2^30 / 100), exact for PROD_W-bit inputs.
  localparam int          DIV_SHIFT  = 30;
  localparam int          RECIP_W    = 24;
  localparam logic [23:0] DIV_RECIP  = 24'd10737419;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] slot_id;
    logic       id_ok;
    logic       rumble;
    logic       start;
    logic       mag_zero;
    logic       used;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [15:0] level;
    logic [15:0] dur;
  } beat_t;

endpackage

### src/rpdd_slot_table.sv
// Effect slot table: magnitude/duration memory, used bits and the input register.
module rpdd_slot_table #(
  parameter int SLOT_COUNT = rpdd_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_slot_id,
  input  logic [15:0]           in_strong_magnitude,
  input  logic [15:0]           in_weak_magnitude,
  input  logic [15:0]           in_duration_ms,
  input  logic                  in_is_rumble_type,
  input  logic                  in_play_start,
  input  logic                  dn_ready,
  output logic                  dn_valid,
  output rpdd_pkg::beat_t       dn_beat
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [31:0]           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] used_r;
  logic [31:0]           rd_r;
  rpdd_pkg::item_t       item_r;
  logic                  valid_r;

  logic [IDX_W-1:0] idx;
  logic             id_ok;
  logic [15:0]      mag;
  logic             accept;
  logic             wr_en;

  assign idx      = in_slot_id[IDX_W-1:0];
  assign id_ok    = in_slot_id < 8'(SLOT_COUNT);
  assign mag      = (in_strong_magnitude > in_weak_magnitude) ? in_strong_magnitude
                                                              : in_weak_magnitude;
  assign in_ready = !valid_r || dn_ready;
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_action == rpdd_pkg::ACT_UPLOAD) && in_is_rumble_type && id_ok;

  // table write and registered read happen at the transfer edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= {mag, in_duration_ms};
    end
    if (accept) begin
      rd_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_en) begin
      used_r[idx] <= 1'b1;
    end else if (accept && (in_action == rpdd_pkg::ACT_ERASE) && id_ok) begin
      used_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action   <= in_action;
      item_r.slot_id  <= in_slot_id;
      item_r.id_ok    <= id_ok;
      item_r.rumble   <= in_is_rumble_type;
      item_r.start    <= in_play_start;
      item_r.mag_zero <= (mag == 16'd0);
      item_r.used     <= id_ok && used_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = {item_r, rd_r};

endmodule

### src/rpdd_scale.sv
// Two-stage strength scaling: multiply by percent, then divide by 100 with rounding.
module rpdd_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rpdd_pkg::beat_t up_beat,
  input  logic [6:0]      strength,
  input  logic            dn_ready,
  output logic            dn_valid,
  output rpdd_pkg::beat_t dn_beat
);

  localparam int QPROD_W = rpdd_pkg::PROD_W + rpdd_pkg::RECIP_W;

  logic                          v2_r;
  rpdd_pkg::beat_t               b2_r;
  logic [rpdd_pkg::PROD_W-1:0]   x2_r;
  logic                          v3_r;
  rpdd_pkg::beat_t               b3_r;

  logic                          s3_ready;
  logic [rpdd_pkg::PROD_W-1:0]   x2_nxt;
  logic [QPROD_W-1:0]            q_prod;

  assign s3_ready = !v3_r || dn_ready;
  assign up_ready = !v2_r || s3_ready;

  assign x2_nxt = rpdd_pkg::PROD_W'(up_beat.level) * rpdd_pkg::PROD_W'(strength)
                + rpdd_pkg::PROD_W'(rpdd_pkg::ROUND_BIAS);
  assign q_prod = QPROD_W'(x2_r) * QPROD_W'(rpdd_pkg::DIV_RECIP);

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      b2_r <= up_beat;
      x2_r <= x2_nxt;
    end
    if (v2_r && s3_ready) begin
      b3_r.item  <= b2_r.item;
      b3_r.dur   <= b2_r.dur;
      b3_r.level <= q_prod[rpdd_pkg::DIV_SHIFT +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (up_ready) begin
        v2_r <= up_valid;
      end
      if (s3_ready) begin
        v3_r <= v2_r;
      end
    end
  end

  assign dn_valid = v3_r;
  assign dn_beat  = b3_r;

endmodule

### src/rpdd_effect_core.sv
// Effect state, millisecond timer, density accumulator and result register.
module rpdd_effect_core #(
  parameter int SLOT_COUNT = rpdd_pkg::SLOT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rpdd_pkg::beat_t up_beat,
  input  logic            cfg_valid,
  input  logic [6:0]      cfg_data,
  output logic [6:0]      strength,
  input  logic            out_stall,
  output logic            out_valid,
  output logic            out_motor_drive,
  output logic [1:0]      out_status,
  output logic            out_effect_active,
  output logic [3:0]      out_active_slot
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [6:0]       strength_r;
  logic             playing_r, armed_r, motor_r;
  logic [IDX_W-1:0] pslot_r;
  logic [15:0]      remain_r, target_r, acc_r;

  logic             playing_nxt, armed_nxt, motor_nxt;
  logic [IDX_W-1:0] pslot_nxt;
  logic [15:0]      remain_nxt, target_nxt, acc_nxt;
  logic [1:0]       status_nxt;

  logic             out_valid_r, motor_out_r, active_out_r;
  logic [1:0]       status_out_r;
  logic [3:0]       slot_out_r;

  logic             item_go, cfg_go, stop;
  logic [6:0]       cfg_clip;
  logic [IDX_W-1:0] idx;
  logic             hit;
  logic [15:0]      rem_dec;

  // one density step: returns {accumulator, motor level}
  function automatic logic [16:0] advance(input logic [15:0] target, input logic [15:0] acc);
    logic [16:0] sum;
    logic [16:0] res;
    sum = {1'b0, acc} + {1'b0, target};
    if (target == 16'd0) begin
      res = {acc, 1'b0};
    end else if (target == rpdd_pkg::FULL_LEVEL) begin
      res = {acc, 1'b1};
    end else if (sum >= {1'b0, rpdd_pkg::FULL_LEVEL}) begin
      res = {16'(sum - {1'b0, rpdd_pkg::FULL_LEVEL}), 1'b1};
    end else begin
      res = {sum[15:0], 1'b0};
    end
    return res;
  endfunction

  assign up_ready = !out_valid_r || !out_stall;
  assign item_go  = up_valid && up_ready;
  assign cfg_clip = (cfg_data > rpdd_pkg::STRENGTH_MAX) ? rpdd_pkg::STRENGTH_MAX : cfg_data;
  assign cfg_go   = cfg_valid && (cfg_clip != strength_r);
  assign idx      = up_beat.item.slot_id[IDX_W-1:0];
  assign hit      = playing_r && (pslot_r == idx);
  assign rem_dec  = (remain_r != 16'd0) ? remain_r - 16'd1 : remain_r;

  always_comb begin
    playing_nxt = playing_r;
    armed_nxt   = armed_r;
    motor_nxt   = motor_r;
    pslot_nxt   = pslot_r;
    remain_nxt  = remain_r;
    target_nxt  = target_r;
    acc_nxt     = acc_r;
    status_nxt  = rpdd_pkg::ST_DONE;
    stop        = 1'b0;

    if (item_go) begin
      case (up_beat.item.action)
        rpdd_pkg::ACT_TICK: begin
          if (armed_r && playing_r) begin
            remain_nxt = rem_dec;
            stop       = (rem_dec == 16'd0);
          end
          if (playing_r && !stop) begin
            {acc_nxt, motor_nxt} = advance(target_r, acc_r);
          end
        end
        rpdd_pkg::ACT_UPLOAD: begin
          if (!up_beat.item.rumble || !up_beat.item.id_ok) begin
            status_nxt = rpdd_pkg::ST_REJECT;
          end else if (hit && up_beat.item.mag_zero) begin
            stop = 1'b1;
          end
        end
        rpdd_pkg::ACT_ERASE: begin
          if (!up_beat.item.id_ok) begin
            status_nxt = rpdd_pkg::ST_REJECT;
          end else if (hit) begin
            stop = 1'b1;
          end
        end
        rpdd_pkg::ACT_PLAY: begin
          if (!up_beat.item.start) begin
            stop = 1'b1;
          end else if (!up_beat.item.id_ok || !up_beat.item.used) begin
            status_nxt = rpdd_pkg::ST_IGNORED;
          end else begin
            playing_nxt          = 1'b1;
            pslot_nxt            = idx;
            armed_nxt            = (up_beat.dur != 16'd0);
            remain_nxt           = up_beat.dur;
            target_nxt           = up_beat.level;
            {acc_nxt, motor_nxt} = advance(up_beat.level, 16'd0);
          end
        end
        default: begin
          status_nxt = rpdd_pkg::ST_DONE;
        end
      endcase
    end

    // a changed strength drops the running effect as well
    if (stop || cfg_go) begin
      playing_nxt = 1'b0;
      pslot_nxt   = '0;
      armed_nxt   = 1'b0;
      remain_nxt  = 16'd0;
      target_nxt  = 16'd0;
      acc_nxt     = 16'd0;
      motor_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= rpdd_pkg::STRENGTH_RESET;
      playing_r  <= 1'b0;
      armed_r    <= 1'b0;
      motor_r    <= 1'b0;
      pslot_r    <= '0;
      remain_r   <= 16'd0;
      target_r   <= 16'd0;
      acc_r      <= 16'd0;
    end else begin
      if (cfg_valid) begin
        strength_r <= cfg_clip;
      end
      playing_r <= playing_nxt;
      armed_r   <= armed_nxt;
      motor_r   <= motor_nxt;
      pslot_r   <= pslot_nxt;
      remain_r  <= remain_nxt;
      target_r  <= target_nxt;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      motor_out_r  <= motor_nxt;
      status_out_r <= status_nxt;
      active_out_r <= playing_nxt;
      slot_out_r   <= playing_nxt ? 4'(pslot_nxt) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  assign strength          = strength_r;
  assign out_valid         = out_valid_r;
  assign out_motor_drive   = motor_out_r;
  assign out_status        = status_out_r;
  assign out_effect_active = active_out_r;
  assign out_active_slot   = slot_out_r;

endmodule

### src/rumble_effect_pulse_density_driver.sv
// Top level of the rumble effect driver with pulse-density motor switching.
//
//   channel  direction  handshake          payload
//   in_      sink       in_valid/in_stall  action, slot, magnitudes, duration, flags
//   out_     source     out_valid/out_stall motor level, status, active flag and slot
//   cfg_     sink       cfg_valid/cfg_ready strength percent (7 bits)
//
// One item per clock while out_stall stays low; a result passes the table read at
// the transfer edge, then the percent multiply, the divide-by-100 multiply and the
// effect state update before it enters the output register.
// Reset (rst_n low, synchronous) empties the pipeline, frees all slots, stops
// the motor and sets strength to 100 percent. Slot contents are not cleared.
// out_stall backs up stage by stage; in_stall rises only with every stage full.
module rumble_effect_pulse_density_driver #(
  parameter int SLOT_COUNT = rpdd_pkg::SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_slot_id,
  input  logic [15:0] in_strong_magnitude,
  input  logic [15:0] in_weak_magnitude,
  input  logic [15:0] in_duration_ms,
  input  logic        in_is_rumble_type,
  input  logic        in_play_start,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_motor_drive,
  output logic [1:0]  out_status,
  output logic        out_effect_active,
  output logic [3:0]  out_active_slot,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_strength_percent
);

  logic            in_ready;
  logic            s1_valid, s1_ready;
  rpdd_pkg::beat_t s1_beat;
  logic            s3_valid, s3_ready;
  rpdd_pkg::beat_t s3_beat;
  logic [6:0]      strength;

  // strength writes must arrive only while idle; unenforced, so take them at once
  assign cfg_ready = 1'b1;
  assign in_stall  = !in_ready;

  // stage 1: table update on upload/erase, registered read for play
  rpdd_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_slot_id          (in_slot_id),
    .in_strong_magnitude (in_strong_magnitude),
    .in_weak_magnitude   (in_weak_magnitude),
    .in_duration_ms      (in_duration_ms),
    .in_is_rumble_type   (in_is_rumble_type),
    .in_play_start       (in_play_start),
    .dn_ready            (s1_ready),
    .dn_valid            (s1_valid),
    .dn_beat             (s1_beat)
  );

  // stages 2 and 3: rounded percent scaling of the stored magnitude
  rpdd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_beat  (s1_beat),
    .strength (strength),
    .dn_ready (s3_ready),
    .dn_valid (s3_valid),
    .dn_beat  (s3_beat)
  );

  // stage 4: effect state, timer and accumulator; holds the result
  rpdd_effect_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (s3_valid),
    .up_ready          (s3_ready),
    .up_beat           (s3_beat),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_data          (cfg_strength_percent),
    .strength          (strength),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_motor_drive   (out_motor_drive),
    .out_status        (out_status),
    .out_effect_active (out_effect_active),
    .out_active_slot   (out_active_slot)
  );

endmodule

### src/rpdd_checker.sv
// Port-level checks of the rumble driver, bound to the top level.
module rpdd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_motor_drive,
  input logic [1:0] out_status,
  input logic       out_effect_active,
  input logic [3:0] out_active_slot
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_motor_drive)
      && $stable(out_effect_active) && $stable(out_active_slot))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == rpdd_pkg::ST_DONE) || (out_status == rpdd_pkg::ST_REJECT)
      || (out_status == rpdd_pkg::ST_IGNORED))
    else $error("status code out of range");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_effect_active |-> out_active_slot == 4'd0)
    else $error("slot reported with no effect active");

  a_idle_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_effect_active |-> !out_motor_drive)
    else $error("motor on with no effect active");

endmodule

bind rumble_effect_pulse_density_driver rpdd_checker u_rpdd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_motor_drive   (out_motor_drive),
  .out_status        (out_status),
  .out_effect_active (out_effect_active),
  .out_active_slot   (out_active_slot)
);

### verif/tb_rumble_effect_pulse_density_driver.sv
`timescale 1ns / 100ps
// Self-checking testbench: predicts the rumble driver's results and checks them in order.

module tb_rumble_effect_pulse_density_driver;

  localparam int NUM_SLOTS = rpdd_pkg::SLOT_COUNT_DEF;

  // One command as presented on the in_ channel.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  slot_id;
    logic [15:0] strong_mag;
    logic [15:0] weak_mag;
    logic [15:0] dur_ms;
    logic        rumble;
    logic        start;
  } rumble_cmd_t;

  // One result as seen on the out_ channel.
  typedef struct packed {
    logic       motor_drive;
    logic [1:0] status;
    logic       effect_active;
    logic [3:0] active_slot;
  } drive_state_t;

  // Track the effect slots and motor state, and queue the drive state each command leads to.
  class drive_result_board;
    bit           slot_used [NUM_SLOTS];
    bit [15:0]    slot_mag  [NUM_SLOTS];
    bit [15:0]    slot_dur  [NUM_SLOTS];
    bit           playing;
    bit [7:0]     play_slot;
    bit           timer_on;
    bit [15:0]    ms_left;
    bit [15:0]    target;
    bit [16:0]    accum;
    bit           motor;
    bit [6:0]     strength;
    drive_state_t pending_drive [$];
    int           mismatches;
    int           checked;
    int           drive_high_seen;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      halt();
      strength = rpdd_pkg::STRENGTH_RESET;
    endfunction

    function void halt();
      playing   = 1'b0;
      play_slot = '0;
      timer_on  = 1'b0;
      ms_left   = '0;
      target    = '0;
      accum     = '0;
      motor     = 1'b0;
    endfunction

    // First-order pulse density: an accumulator sum at or above FULL_LEVEL switches the motor on.
    function void advance();
      bit [16:0] sum;
      if (target == 16'd0) begin
        motor = 1'b0;
      end else if (target == rpdd_pkg::FULL_LEVEL) begin
        motor = 1'b1;
      end else begin
        sum = accum + target;
        if (sum >= rpdd_pkg::FULL_LEVEL) begin
          accum = sum - rpdd_pkg::FULL_LEVEL;
          motor = 1'b1;
        end else begin
          accum = sum;
          motor = 1'b0;
        end
      end
    endfunction

    function void set_strength(bit [6:0] v);
      bit [6:0] s;
      s = (v > rpdd_pkg::STRENGTH_MAX) ? rpdd_pkg::STRENGTH_MAX : v;
      if (s != strength) begin
        halt();
        strength = s;
      end
    endfunction

    function void take_command(rumble_cmd_t c);
      bit [1:0]     status;
      bit [15:0]    mag;
      int unsigned  scaled;
      drive_state_t r;
      status = rpdd_pkg::ST_DONE;
      case (c.action)
        rpdd_pkg::ACT_TICK: begin
          if (timer_on && playing) begin
            if (ms_left > 0) ms_left--;
            if (ms_left == 0) halt();
          end
          if (playing) advance();
        end
        rpdd_pkg::ACT_UPLOAD: begin
          if (!c.rumble || c.slot_id >= NUM_SLOTS) begin
            status = rpdd_pkg::ST_REJECT;
          end else begin
            mag = (c.strong_mag > c.weak_mag) ? c.strong_mag : c.weak_mag;
            slot_mag[c.slot_id]  = mag;
            slot_dur[c.slot_id]  = c.dur_ms;
            slot_used[c.slot_id] = 1'b1;
            if (playing && play_slot == c.slot_id && mag == 16'd0) halt();
          end
        end
        rpdd_pkg::ACT_ERASE: begin
          if (c.slot_id >= NUM_SLOTS) begin
            status = rpdd_pkg::ST_REJECT;
          end else begin
            slot_used[c.slot_id] = 1'b0;
            if (playing && play_slot == c.slot_id) halt();
          end
        end
        default: begin
          if (!c.start) begin
            halt();
          end else if (c.slot_id >= NUM_SLOTS || !slot_used[c.slot_id]) begin
            status = rpdd_pkg::ST_IGNORED;
          end else begin
            scaled    = (slot_mag[c.slot_id] * strength + 50) / 100;
            playing   = 1'b1;
            play_slot = c.slot_id;
            timer_on  = slot_dur[c.slot_id] != 16'd0;
            ms_left   = slot_dur[c.slot_id];
            target    = scaled[15:0];
            accum     = '0;
            advance();
          end
        end
      endcase
      r.motor_drive   = motor;
      r.status        = status;
      r.effect_active = playing;
      r.active_slot   = playing ? play_slot[3:0] : 4'd0;
      pending_drive.push_back(r);
    endfunction

    function void report(string what, drive_state_t want, drive_state_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s: expected motor=%0b status=%0d active=%0b slot=%0d,",
                 $time, what, want.motor_drive, want.status, want.effect_active,
                 want.active_slot,
                 " got motor=%0b status=%0d active=%0b slot=%0d",
                 got.motor_drive, got.status, got.effect_active, got.active_slot);
    endfunction

    function void compare_drive(drive_state_t got);
      drive_state_t want;
      string        bad;
      if (pending_drive.size() == 0) begin
        report("result with nothing outstanding", '0, got);
        return;
      end
      want = pending_drive.pop_front();
      checked++;
      if (got.motor_drive === 1'b1) drive_high_seen++;
      bad = "";
      if (got.motor_drive !== want.motor_drive) bad = {bad, " motor_drive"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.effect_active !== want.effect_active) bad = {bad, " effect_active"};
      if (got.active_slot !== want.active_slot) bad = {bad, " active_slot"};
      if (bad != "") report({"mismatch in", bad}, want, got);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_slot_id;
  logic [15:0] in_strong_magnitude;
  logic [15:0] in_weak_magnitude;
  logic [15:0] in_duration_ms;
  logic        in_is_rumble_type;
  logic        in_play_start;
  logic        out_valid;
  logic        out_stall;
  logic        out_motor_drive;
  logic [1:0]  out_status;
  logic        out_effect_active;
  logic [3:0]  out_active_slot;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_strength_percent;

  drive_result_board board = new();

  int n_sent;
  int n_cfg;
  bit gaps_on;
  bit stall_mix;
  int stall_run;
  bit stall_level;
  int stall_pick;

  rumble_effect_pulse_density_driver #(
    .SLOT_COUNT(NUM_SLOTS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_slot_id          (in_slot_id),
    .in_strong_magnitude (in_strong_magnitude),
    .in_weak_magnitude   (in_weak_magnitude),
    .in_duration_ms      (in_duration_ms),
    .in_is_rumble_type   (in_is_rumble_type),
    .in_play_start       (in_play_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_motor_drive     (out_motor_drive),
    .out_status          (out_status),
    .out_effect_active   (out_effect_active),
    .out_active_slot     (out_active_slot),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_strength_percent(cfg_strength_percent)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure: runs of no stall, short stalls and the odd long one.
  // With stall_mix off, keep the result channel wide open.
  always @(negedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (!stall_mix) begin
      stall_level = 1'b0;
    end else begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 55) begin
        stall_level = 1'b0;
        stall_run   = $urandom_range(7);
      end else if (stall_pick < 93) begin
        stall_level = 1'b1;
        stall_run   = $urandom_range(2);
      end else begin
        stall_level = 1'b1;
        stall_run   = $urandom_range(29, 5);
      end
    end
    out_stall <= stall_level;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      board.compare_drive({out_motor_drive, out_status, out_effect_active, out_active_slot});
  end

  // Sender gap length: mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // Drive one command after its gap, hold it until transferred, then log it.
  task automatic send_cmd(input rumble_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_action           <= c.action;
    in_slot_id          <= c.slot_id;
    in_strong_magnitude <= c.strong_mag;
    in_weak_magnitude   <= c.weak_mag;
    in_duration_ms      <= c.dur_ms;
    in_is_rumble_type   <= c.rumble;
    in_play_start       <= c.start;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_command(c);
    n_sent++;
  endtask

  task automatic send_now(input logic [1:0] act, input logic [7:0] slot,
                          input logic [15:0] strong_m, input logic [15:0] weak_m,
                          input logic [15:0] dur, input logic rumble, input logic start);
    send_cmd('{act, slot, strong_m, weak_m, dur, rumble, start});
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_drive.size() != 0) @(posedge clk);
  endtask

  // Write strength only with the pipeline empty, and mirror it in the prediction.
  task automatic write_strength(input logic [6:0] v);
    hold_until_drained();
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_strength_percent <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.set_strength(v);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_mag();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'hFFFF;
    if (r < 50) return 16'($urandom_range(300));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Mostly short replay lengths so expiry shows up within a scene.
  function automatic logic [15:0] rand_dur();
    int r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 75) return 16'($urandom_range(12, 1));
    if (r < 90) return 16'($urandom_range(200, 13));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic rumble_cmd_t rand_cmd();
    rumble_cmd_t c;
    int          r;
    r = $urandom_range(99);
    if (r < 50)      c.action = rpdd_pkg::ACT_TICK;
    else if (r < 70) c.action = rpdd_pkg::ACT_UPLOAD;
    else if (r < 80) c.action = rpdd_pkg::ACT_ERASE;
    else             c.action = rpdd_pkg::ACT_PLAY;
    if ($urandom_range(99) < 88) c.slot_id = 8'($urandom_range(NUM_SLOTS - 1));
    else                         c.slot_id = 8'($urandom_range(255));
    c.strong_mag = rand_mag();
    c.weak_mag   = rand_mag();
    c.dur_ms     = rand_dur();
    c.rumble     = $urandom_range(99) < 90;
    c.start      = $urandom_range(99) < 85;
    return c;
  endfunction

  // Well-formed scene: upload a slot, play it, then mostly ticks with a few
  // stray commands mixed in. Noise commands fill the rest.
  task automatic run_phase(input int count);
    int          stop_at;
    int          n;
    logic [7:0]  s;
    rumble_cmd_t c;
    stop_at = n_sent + count;
    while (n_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        s = 8'($urandom_range(NUM_SLOTS - 1));
        c = rand_cmd();
        c.action  = rpdd_pkg::ACT_UPLOAD;
        c.slot_id = s;
        c.rumble  = 1'b1;
        send_cmd(c);
        c = rand_cmd();
        c.action  = rpdd_pkg::ACT_PLAY;
        c.slot_id = s;
        c.start   = 1'b1;
        send_cmd(c);
        n = $urandom_range(25, 2);
        repeat (n) begin
          c = rand_cmd();
          if ($urandom_range(9) != 0) c.action = rpdd_pkg::ACT_TICK;
          send_cmd(c);
        end
        // Now and then let the block run dry before the next scene.
        if ($urandom_range(19) == 0) hold_until_drained();
      end else begin
        send_cmd(rand_cmd());
      end
    end
  endtask

  // Hand-picked commands: rejects, ignores, full level, expiry, zero upload and
  // erase of the playing slot, stop with any slot, zero scaled level.
  task automatic run_directed();
    send_now(rpdd_pkg::ACT_TICK,   8'd0,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd16,  16'd100,    16'd0,      16'd5,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd3,   16'd100,    16'd0,      16'd5,      1'b0, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd5,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd200, 16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_ERASE,  8'd255, 16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd250, 16'd0,      16'd0,      16'd0,      1'b1, 1'b0);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd0,   16'hFFFF,   16'd0,      16'd0,      1'b1, 1'b0);
    send_now(rpdd_pkg::ACT_PLAY,   8'd0,   16'd0,      16'd0,      16'd0,      1'b0, 1'b1);
    send_now(rpdd_pkg::ACT_TICK,   8'd0,   16'd0,      16'd0,      16'd0,      1'b0, 1'b0);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd15,  16'd0,      16'd30000,  16'd3,      1'b1, 1'b0);
    send_now(rpdd_pkg::ACT_PLAY,   8'd15,  16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    repeat (3) send_now(rpdd_pkg::ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd1,   16'd1,      16'd0,      16'd2,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd1,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd1,   16'd0,      16'd0,      16'd9,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd1,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_TICK,   8'd0,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_ERASE,  8'd1,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_UPLOAD, 8'd7,   16'h1234,   16'hFEDC,   16'hFFFF,   1'b1, 1'b0);
    send_now(rpdd_pkg::ACT_PLAY,   8'd7,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_TICK,   8'd0,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_ERASE,  8'd0,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
    send_now(rpdd_pkg::ACT_PLAY,   8'd0,   16'd0,      16'd0,      16'd0,      1'b1, 1'b1);
  endtask

  // Main sequence: reset, directed commands, then random phases under a range
  // of strength settings (zero, one, out of range, full, repeats and random).
  initial begin
    logic [6:0] levels [8];
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_action            = rpdd_pkg::ACT_TICK;
    in_slot_id           = '0;
    in_strong_magnitude  = '0;
    in_weak_magnitude    = '0;
    in_duration_ms       = '0;
    in_is_rumble_type    = 1'b0;
    in_play_start        = 1'b0;
    out_stall            = 1'b0;
    cfg_valid            = 1'b0;
    cfg_strength_percent = '0;
    n_sent               = 0;
    n_cfg                = 0;
    stall_run            = 0;
    stall_level          = 1'b0;
    gaps_on              = 1'b1;
    stall_mix            = 1'b1;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // 127 acts as 100, so the 100 that follows it must not stop the effect.
    levels = '{7'd0, 7'd1, 7'd127, 7'd100, 7'd50, 7'd99, 7'($urandom_range(127)), 7'd100};
    foreach (levels[p]) begin
      write_strength(levels[p]);
      // Vary idling per phase, including a phase with none on either side.
      gaps_on   = (p % 3) != 2;
      stall_mix = (p % 4) != 1 && p != 2;
      run_phase(190);
    end

    // Drain and let the pipeline settle before the verdict.
    hold_until_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d commands under %0d strength writes;", n_sent, n_cfg,
             " %0d results checked, %0d with the motor on.",
             board.checked, board.drive_high_seen);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             board.mismatches, board.pending_drive.size());
    if (board.mismatches == 0 && board.pending_drive.size() == 0) begin
      $display("PASS rumble_effect_pulse_density_driver");
    end else begin
      $display("FAIL rumble_effect_pulse_density_driver");
    end
    $finish;
  end

  // Watchdog: bail out if the run hangs.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding after %0d commands.",
             board.pending_drive.size(), n_sent);
    $display("FAIL rumble_effect_pulse_density_driver");
    $finish;
  end

endmodule

### sim.f
src/rpdd_pkg.sv
src/rpdd_slot_table.sv
src/rpdd_scale.sv
src/rpdd_effect_core.sv
src/rumble_effect_pulse_density_driver.sv
src/rpdd_checker.sv
verif/tb_rumble_effect_pulse_density_driver.sv
